FILE: hw/rtl/mrrpt_pkg.sv
// Shared types and constants for the multi-reader ring pointer tracker.
`default_nettype none

package mrrpt_pkg;

    localparam int CFG_W           = 5;
    localparam int CFG_RESET       = 12;
    localparam int LG_MIN          = 1;
    localparam int LG_LIMIT        = 16;
    localparam int DEF_MAX_READERS = 4;
    localparam int DEF_INDEX_BITS  = 16;
    localparam int OP_W            = 3;
    localparam int ID_W            = 2;
    localparam int COUNT_W         = 16;
    localparam int POS_W           = 16;
    localparam int TOTAL_W         = 48;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 3'd0,
        OP_READ   = 3'd1,
        OP_ATTACH = 3'd2,
        OP_DETACH = 3'd3,
        OP_QUERY  = 3'd4
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [ID_W-1:0]    reader_id;
        logic [COUNT_W-1:0] count;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]   space_free;
        logic [POS_W-1:0]   reader_backlog;
        logic [POS_W-1:0]   write_position;
        logic [POS_W-1:0]   read_position;
        logic [TOTAL_W-1:0] total_written;
        logic [TOTAL_W-1:0] total_read;
        logic               reader_active;
        logic               error;
    } t_out_item;

    typedef struct packed {
        logic            vld;
        logic [ID_W-1:0] reader_id;
        logic            exists;
        logic            err;
    } t_op_info;

endpackage

`default_nettype wire

FILE: hw/rtl/mrrpt_state.sv
// Pointer state registers and per-operation update.
`default_nettype none

module mrrpt_state
    import mrrpt_pkg::*;
#(
    parameter int MAX_READERS = DEF_MAX_READERS,
    parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire logic                  i_item_vld,
    input  wire t_in_item              i_item,
    input  wire logic [INDEX_BITS-1:0] i_mask,
    output t_op_info                   o_info,
    output logic [INDEX_BITS-1:0]      o_wr_idx,
    output logic [TOTAL_W-1:0]         o_wr_total,
    output logic [INDEX_BITS-1:0]      o_rd_idx   [MAX_READERS],
    output logic [TOTAL_W-1:0]         o_rd_total [MAX_READERS],
    output logic [MAX_READERS-1:0]     o_rd_vld
);

    logic [INDEX_BITS-1:0]  r_wr_idx, n_wr_idx;
    logic [TOTAL_W-1:0]     r_wr_total, n_wr_total;
    logic [INDEX_BITS-1:0]  r_rd_idx   [MAX_READERS];
    logic [INDEX_BITS-1:0]  n_rd_idx   [MAX_READERS];
    logic [TOTAL_W-1:0]     r_rd_total [MAX_READERS];
    logic [TOTAL_W-1:0]     n_rd_total [MAX_READERS];
    logic [MAX_READERS-1:0] r_rd_vld, n_rd_vld;
    t_op_info               r_info, n_info;

    logic [MAX_READERS-1:0] sel;
    logic                   exists;
    logic                   hit;
    logic [INDEX_BITS-1:0]  wi_m;
    logic [INDEX_BITS-1:0]  cnt_ix;

    always_comb begin
        exists = int'(i_item.reader_id) < MAX_READERS;
        for (int i = 0; i < MAX_READERS; i++) begin
            sel[i] = exists && (int'(i_item.reader_id) == i);
        end
        hit    = |(sel & r_rd_vld);
        wi_m   = r_wr_idx & i_mask;
        cnt_ix = INDEX_BITS'(i_item.count);

        n_wr_idx   = wi_m;
        n_wr_total = r_wr_total;
        n_rd_vld   = r_rd_vld;
        for (int i = 0; i < MAX_READERS; i++) begin
            n_rd_idx[i]   = r_rd_idx[i] & i_mask;
            n_rd_total[i] = r_rd_total[i];
        end
        n_info.vld       = i_item_vld;
        n_info.reader_id = i_item.reader_id;
        n_info.exists    = exists;
        n_info.err       = 1'b0;

        case (i_item.op)
            OP_WRITE: begin
                n_wr_idx   = (wi_m + cnt_ix) & i_mask;
                n_wr_total = r_wr_total + TOTAL_W'(i_item.count);
            end
            OP_READ: begin
                n_info.err = !hit;
                for (int i = 0; i < MAX_READERS; i++) begin
                    if (sel[i] && r_rd_vld[i]) begin
                        n_rd_idx[i]   = (r_rd_idx[i] + cnt_ix) & i_mask;
                        n_rd_total[i] = r_rd_total[i] + TOTAL_W'(i_item.count);
                    end
                end
            end
            OP_ATTACH: begin
                n_info.err = !exists;
                for (int i = 0; i < MAX_READERS; i++) begin
                    if (sel[i]) begin
                        n_rd_vld[i]   = 1'b1;
                        n_rd_idx[i]   = wi_m;
                        n_rd_total[i] = '0;
                    end
                end
            end
            OP_DETACH: begin
                n_info.err = !hit;
                n_rd_vld   = r_rd_vld & ~sel;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx   <= '0;
            r_wr_total <= '0;
            r_rd_vld   <= '0;
            r_info     <= '0;
            for (int i = 0; i < MAX_READERS; i++) begin
                r_rd_idx[i]   <= '0;
                r_rd_total[i] <= '0;
            end
        end else if (i_adv) begin
            r_info <= n_info;
            if (i_item_vld) begin
                r_wr_idx   <= n_wr_idx;
                r_wr_total <= n_wr_total;
                r_rd_vld   <= n_rd_vld;
                for (int i = 0; i < MAX_READERS; i++) begin
                    r_rd_idx[i]   <= n_rd_idx[i];
                    r_rd_total[i] <= n_rd_total[i];
                end
            end
        end
    end

    assign o_info     = r_info;
    assign o_wr_idx   = r_wr_idx;
    assign o_wr_total = r_wr_total;
    assign o_rd_idx   = r_rd_idx;
    assign o_rd_total = r_rd_total;
    assign o_rd_vld   = r_rd_vld;

endmodule

`default_nettype wire

FILE: hw/rtl/mrrpt_status.sv
// Backlog, free space and result register.
`default_nettype none

module mrrpt_status
    import mrrpt_pkg::*;
#(
    parameter int MAX_READERS = DEF_MAX_READERS,
    parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire t_op_info              i_info,
    input  wire logic [INDEX_BITS-1:0] i_mask,
    input  wire logic [INDEX_BITS-1:0] i_wr_idx,
    input  wire logic [TOTAL_W-1:0]    i_wr_total,
    input  wire logic [INDEX_BITS-1:0] i_rd_idx   [MAX_READERS],
    input  wire logic [TOTAL_W-1:0]    i_rd_total [MAX_READERS],
    input  wire logic [MAX_READERS-1:0] i_rd_vld,
    output logic                       o_vld,
    output t_out_item                  o_item
);

    localparam int RW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;

    logic [INDEX_BITS-1:0] backlog [MAX_READERS];
    logic [INDEX_BITS-1:0] most;
    logic [INDEX_BITS-1:0] space;
    logic [RW-1:0]         ridx;
    logic                  active;
    t_out_item             n_item;
    t_out_item             r_item;
    logic                  r_vld;

    always_comb begin
        most = '0;
        for (int i = 0; i < MAX_READERS; i++) begin
            backlog[i] = (i_wr_idx - i_rd_idx[i]) & i_mask;
            if (i_rd_vld[i] && (backlog[i] > most)) begin
                most = backlog[i];
            end
        end
        space  = (|i_rd_vld) ? (i_mask - most) : i_mask;
        ridx   = RW'(i_info.reader_id);
        active = i_info.exists && i_rd_vld[ridx];

        n_item.space_free     = POS_W'(space);
        n_item.reader_backlog = active ? POS_W'(backlog[ridx]) : '0;
        n_item.write_position = POS_W'(i_wr_idx);
        n_item.read_position  = active ? POS_W'(i_rd_idx[ridx]) : '0;
        n_item.total_written  = i_wr_total;
        n_item.total_read     = active ? i_rd_total[ridx] : '0;
        n_item.reader_active  = active;
        n_item.error          = i_info.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_info.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_info.vld) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

`default_nettype wire

FILE: hw/rtl/multi_reader_ring_pointer_tracker_core.sv
// Top level of the multi-reader ring pointer tracker.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): one operation per
// transaction: write commit, read commit, attach, detach or query.
// Output channel (o_out_valid / i_out_stall / o_out_item): exactly one result
// per operation, in order, carrying the state after that operation.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the ring size register
// (log2 of the size); write it only while no operation is in flight.
// Pipeline: an operation passes through the input register, the state update
// and the result register. Throughput: one operation per cycle while the
// output is not stalled; the state is registered after every operation, so
// back-to-back operations see each other's effects.
// A stall on a valid output freezes the whole pipeline and raises o_in_stall in
// the same cycle; nothing is lost or repeated.
// Reset: all pointers and totals cleared, no reader attached, ring size
// register back to 12, pipeline empty.
`default_nettype none

module multi_reader_ring_pointer_tracker_core
    import mrrpt_pkg::*;
#(
    parameter int MAX_READERS = DEF_MAX_READERS,
    parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CFG_W-1:0] i_cfg_wr_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_item
);

    localparam int LG_MAX = (INDEX_BITS < LG_LIMIT) ? INDEX_BITS : LG_LIMIT;

    logic [CFG_W-1:0]      r_size_log2;
    logic [CFG_W-1:0]      lg_eff;
    logic [INDEX_BITS-1:0] mask;
    logic                  adv;
    logic                  r_in_vld;
    t_in_item              r_in;

    t_op_info               info;
    logic [INDEX_BITS-1:0]  wr_idx;
    logic [TOTAL_W-1:0]     wr_total;
    logic [INDEX_BITS-1:0]  rd_idx   [MAX_READERS];
    logic [TOTAL_W-1:0]     rd_total [MAX_READERS];
    logic [MAX_READERS-1:0] rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= CFG_W'(CFG_RESET);
        end else if (i_cfg_wr_en) begin
            r_size_log2 <= i_cfg_wr_data;
        end
    end

    always_comb begin
        if (int'(r_size_log2) < LG_MIN) begin
            lg_eff = CFG_W'(LG_MIN);
        end else if (int'(r_size_log2) > LG_MAX) begin
            lg_eff = CFG_W'(LG_MAX);
        end else begin
            lg_eff = r_size_log2;
        end
        for (int b = 0; b < INDEX_BITS; b++) begin
            mask[b] = b < int'(lg_eff);
        end
    end

    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (adv) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in <= i_in_item;
        end
    end

    mrrpt_state #(
        .MAX_READERS (MAX_READERS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_item_vld (r_in_vld),
        .i_item     (r_in),
        .i_mask     (mask),
        .o_info     (info),
        .o_wr_idx   (wr_idx),
        .o_wr_total (wr_total),
        .o_rd_idx   (rd_idx),
        .o_rd_total (rd_total),
        .o_rd_vld   (rd_vld)
    );

    mrrpt_status #(
        .MAX_READERS (MAX_READERS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_status (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_info     (info),
        .i_mask     (mask),
        .i_wr_idx   (wr_idx),
        .i_wr_total (wr_total),
        .i_rd_idx   (rd_idx),
        .i_rd_total (rd_total),
        .i_rd_vld   (rd_vld),
        .o_vld      (o_out_valid),
        .o_item     (o_out_item)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/mrrpt_chk.sv
// Port-level assertion checker for the ring pointer tracker, with its bind.
`default_nettype none

module mrrpt_chk
    import mrrpt_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_item_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("output transaction changed while stalled");

    a_inactive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.reader_active |->
            (o_out_item.reader_backlog == '0) && (o_out_item.read_position == '0)
            && (o_out_item.total_read == '0))
        else $error("inactive reader reports nonzero pointers");

    a_space_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (17'(o_out_item.space_free) + 17'(o_out_item.reader_backlog))
            <= 17'h0FFFF)
        else $error("free space plus backlog exceeds ring size");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind multi_reader_ring_pointer_tracker_core mrrpt_chk u_mrrpt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

FILE: test/ring_pointer_monitor.sv
`timescale 1ns / 1ps
// Monitor for the ring pointer tracker: tracks pointer state, predicts every result and checks it.
module ring_pointer_monitor
    import mrrpt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CFG_W-1:0] i_cfg_wr_data,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_stall,
    input  wire t_in_item         i_in_item,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_stall,
    input  wire t_out_item        i_out_item,
    output int                    o_fail_count,
    output int                    o_pending
);
    localparam int READERS = DEF_MAX_READERS;

    logic [CFG_W-1:0]   ring_log2;
    logic [POS_W-1:0]   wr_idx;
    logic [TOTAL_W-1:0] wr_tot;
    logic [POS_W-1:0]   rd_idx [READERS];
    logic [TOTAL_W-1:0] rd_tot [READERS];
    logic               attached [READERS];
    t_out_item          status_q [$];
    int                 fails = 0;
    int                 waiting = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    task automatic apply_op(input t_in_item it, output t_out_item res);
        logic [CFG_W-1:0] lg;
        logic [POS_W-1:0] mask;
        logic [POS_W-1:0] most;
        logic [POS_W-1:0] lag;
        logic             any;
        logic             err;
        logic             act;
        int               r;
        lg = ring_log2;
        if (int'(lg) < LG_MIN) lg = CFG_W'(LG_MIN);
        if (int'(lg) > LG_LIMIT) lg = CFG_W'(LG_LIMIT);
        mask = POS_W'((32'd1 << lg) - 32'd1);
        r = int'(it.reader_id);
        err = 1'b0;
        wr_idx = wr_idx & mask;
        case (it.op)
            OP_WRITE: begin
                wr_idx = (wr_idx + it.count) & mask;
                wr_tot = wr_tot + TOTAL_W'(it.count);
            end
            OP_READ: begin
                if (attached[r]) begin
                    rd_idx[r] = (rd_idx[r] + it.count) & mask;
                    rd_tot[r] = rd_tot[r] + TOTAL_W'(it.count);
                end else begin
                    err = 1'b1;
                end
            end
            OP_ATTACH: begin
                attached[r] = 1'b1;
                rd_idx[r]   = wr_idx;
                rd_tot[r]   = '0;
            end
            OP_DETACH: begin
                if (attached[r]) attached[r] = 1'b0;
                else err = 1'b1;
            end
            default: ;
        endcase
        any  = 1'b0;
        most = '0;
        for (int i = 0; i < READERS; i++) begin
            rd_idx[i] = rd_idx[i] & mask;
            if (attached[i]) begin
                lag = (wr_idx - rd_idx[i]) & mask;
                if (!any || lag > most) most = lag;
                any = 1'b1;
            end
        end
        act = attached[r];
        res.space_free     = any ? mask - most : mask;
        res.reader_backlog = act ? ((wr_idx - rd_idx[r]) & mask) : '0;
        res.write_position = wr_idx;
        res.read_position  = act ? rd_idx[r] : '0;
        res.total_written  = wr_tot;
        res.total_read     = act ? rd_tot[r] : '0;
        res.reader_active  = act;
        res.error          = err;
    endtask

    task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                               input logic [TOTAL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            ring_log2 = CFG_W'(CFG_RESET);
            wr_idx    = '0;
            wr_tot    = '0;
            for (int i = 0; i < READERS; i++) begin
                rd_idx[i]   = '0;
                rd_tot[i]   = '0;
                attached[i] = 1'b0;
            end
            status_q.delete();
        end else begin
            if (i_cfg_wr_en) ring_log2 = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall) begin
                apply_op(i_in_item, want);
                status_q = {status_q, want};
            end
            if (i_out_valid && !i_out_stall) begin
                if (status_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_out_item);
                    fails++;
                end else begin
                    want = status_q.pop_front();
                    check_field("space_free", TOTAL_W'(want.space_free),
                                TOTAL_W'(i_out_item.space_free));
                    check_field("reader_backlog", TOTAL_W'(want.reader_backlog),
                                TOTAL_W'(i_out_item.reader_backlog));
                    check_field("write_position", TOTAL_W'(want.write_position),
                                TOTAL_W'(i_out_item.write_position));
                    check_field("read_position", TOTAL_W'(want.read_position),
                                TOTAL_W'(i_out_item.read_position));
                    check_field("total_written", want.total_written,
                                i_out_item.total_written);
                    check_field("total_read", want.total_read, i_out_item.total_read);
                    check_field("reader_active", TOTAL_W'(want.reader_active),
                                TOTAL_W'(i_out_item.reader_active));
                    check_field("error", TOTAL_W'(want.error),
                                TOTAL_W'(i_out_item.error));
                end
            end
        end
        waiting = status_q.size();
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Top of the ring pointer tracker testbench: clock, reset, stimulus and verdict.
module tb_top;
    import mrrpt_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_OPS   = 210;
    localparam int PHASES      = 9;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             in_valid;
    logic             in_stall;
    t_in_item         in_item;
    logic             out_valid;
    logic             out_stall;
    t_out_item        out_item;
    int               fail_count;
    int               pending;

    int               src_idle_pct;
    int               rcv_idle_pct;
    int               hold_req;
    int               hold_done;
    int               ring_items;
    logic [3:0]       attached_set;

    multi_reader_ring_pointer_tracker_core dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in_item    (in_item),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_item   (out_item)
    );

    ring_pointer_monitor monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side: random stalls, plus long hold-offs on request
    initial begin
        out_stall = 1'b0;
        hold_done = 0;
        forever begin
            @(negedge clk);
            if (hold_req != hold_done) begin
                hold_done++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("multi_reader_ring_pointer_tracker_core test failed");
        $finish;
    end

    task automatic send_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [COUNT_W-1:0] cnt);
        t_in_item it;
        it.op        = op;
        it.reader_id = id;
        it.count     = cnt;
        if (op == OP_ATTACH) attached_set[id] = 1'b1;
        if (op == OP_DETACH) attached_set[id] = 1'b0;
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic set_ring_log2(input logic [CFG_W-1:0] lg);
        int eff;
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_data <= lg;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        eff = lg;
        if (eff < LG_MIN) eff = LG_MIN;
        if (eff > LG_LIMIT) eff = LG_LIMIT;
        ring_items = 1 << eff;
    endtask

    function automatic logic [COUNT_W-1:0] rand_count();
        int k;
        k = $urandom_range(99);
        if (k < 70) return COUNT_W'($urandom_range(0, ring_items));
        if (k < 90) return COUNT_W'($urandom);
        if (k < 95) return '0;
        return '1;
    endfunction

    function automatic logic [ID_W-1:0] pick_attached();
        logic [ID_W-1:0] id;
        id = ID_W'($urandom);
        if (attached_set == '0 || $urandom_range(9) == 0) return id;
        while (!attached_set[id]) id = ID_W'($urandom);
        return id;
    endfunction

    task automatic random_op();
        int              k;
        logic [ID_W-1:0] id;
        k  = $urandom_range(99);
        id = ID_W'($urandom);
        if (k < 35) send_op(OP_WRITE, id, rand_count());
        else if (k < 65) send_op(OP_READ, pick_attached(), rand_count());
        else if (k < 75) send_op(OP_ATTACH, id, rand_count());
        else if (k < 85) send_op(OP_DETACH, pick_attached(), rand_count());
        else if (k < 95) send_op(OP_QUERY, id, rand_count());
        else send_op(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), id, rand_count());
    endtask

    function automatic logic [CFG_W-1:0] phase_log2(input int p);
        case (p)
            0: return CFG_W'(1);
            1: return CFG_W'(16);
            2: return '0;
            3: return '1;
            4: return CFG_W'(17);
            5: return CFG_W'(4);
            6: return CFG_W'(2);
            7: return CFG_W'(CFG_RESET);
            default: return CFG_W'($urandom_range(2, 15));
        endcase
    endfunction

    initial begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        in_item      = '0;
        src_idle_pct = 13;
        rcv_idle_pct = 59;
        hold_req     = 0;
        ring_items   = 1 << CFG_RESET;
        attached_set = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_op(OP_QUERY, 2'd0, '0);
        send_op(OP_READ, 2'd1, 16'd5);
        send_op(OP_DETACH, 2'd2, '0);
        send_op(OP_WRITE, 2'd0, '0);
        send_op(OP_WRITE, 2'd3, '1);
        send_op(OP_ATTACH, 2'd0, '0);
        send_op(OP_ATTACH, 2'd3, '1);
        send_op(OP_WRITE, 2'd1, 16'd100);
        send_op(OP_READ, 2'd0, 16'd50);
        send_op(OP_QUERY, 2'd3, '0);
        // re-attach of an active reader
        send_op(OP_ATTACH, 2'd0, 16'd7);
        send_op(OP_READ, 2'd3, '1);
        send_op(OP_SPARE_LO, 2'd0, 16'h5555);
        send_op(OP_SPARE_HI, 2'd3, 16'hAAAA);
        send_op(OP_DETACH, 2'd3, '0);
        send_op(OP_WRITE, 2'd2, 16'd4095);
        send_op(OP_READ, 2'd0, '1);
        send_op(OP_ATTACH, 2'd1, '0);
        send_op(OP_WRITE, 2'd0, 16'd3000);
        // shrink the ring under live pointers
        set_ring_log2(CFG_W'(4));
        send_op(OP_QUERY, 2'd1, '0);
        send_op(OP_WRITE, 2'd0, 16'd9);
        send_op(OP_DETACH, 2'd0, '0);
        send_op(OP_QUERY, 2'd0, '0);

        for (int p = 0; p < PHASES; p++) begin
            if (p == 3) begin
                src_idle_pct = 59;
                rcv_idle_pct = 13;
            end
            if (p == 6) begin
                src_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            set_ring_log2(phase_log2(p));
            for (int n = 0; n < PHASE_OPS; n++) begin
                if (n == PHASE_OPS / 2 && (p == 1 || p == 7)) hold_req++;
                random_op();
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("multi_reader_ring_pointer_tracker_core test passed");
        else
            $display("multi_reader_ring_pointer_tracker_core test failed");
        $finish;
    end

endmodule
